>>> rtl/core/mqdc_pkg.sv
// Shared types and constants for the multi-channel quadrature detent counter.
// Used by the lane decoder, the top level and the port checker.
`default_nettype none

package mqdc_pkg;

    localparam int LANES             = 8;
    localparam int NUM_ENCODERS_DEF  = 8;
    localparam int POSITION_BITS_DEF = 16;
    localparam int OUT_BITS          = 16;
    localparam int PORT_BITS         = 8;
    localparam int PIN_BITS          = 4;
    localparam int PINS              = 2 * PORT_BITS;
    localparam int CFG_INDEX_BITS    = 8;
    localparam int CFG_DATA_BITS     = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_A_PIN_SELECT = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_B_PIN_SELECT = 8'd1;

    localparam logic [CFG_DATA_BITS-1:0] A_PIN_SELECT_RST = 32'hEC02579A;
    localparam logic [CFG_DATA_BITS-1:0] B_PIN_SELECT_RST = 32'hFD13468B;

    // Detent state: both signals low
    localparam logic [1:0] AB_DETENT = 2'b00;

    // Quadrature step, indexed by {previous AB, current AB}
    localparam logic signed [1:0] STEP_TABLE [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    typedef struct packed {
        logic [PORT_BITS-1:0] port_a_bits;
        logic [PORT_BITS-1:0] port_b_bits;
    } t_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] enc0_position;
        logic signed [OUT_BITS-1:0] enc1_position;
        logic signed [OUT_BITS-1:0] enc2_position;
        logic signed [OUT_BITS-1:0] enc3_position;
        logic signed [OUT_BITS-1:0] enc4_position;
        logic signed [OUT_BITS-1:0] enc5_position;
        logic signed [OUT_BITS-1:0] enc6_position;
        logic signed [OUT_BITS-1:0] enc7_position;
    } t_out;

endpackage

`default_nettype wire

>>> rtl/core/mqdc_lane.sv
// One encoder decoder: pin selection, AB transition lookup and detent position register.
// Depends on mqdc_pkg for the step table and pin widths.
`default_nettype none

module mqdc_lane #(
    parameter int POSITION_BITS = mqdc_pkg::POSITION_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_step,
    input  wire  [mqdc_pkg::PINS-1:0]          i_levels,
    input  wire  [mqdc_pkg::PIN_BITS-1:0]      i_a_pin,
    input  wire  [mqdc_pkg::PIN_BITS-1:0]      i_b_pin,
    output logic signed [POSITION_BITS-1:0]    o_position
);

    logic [1:0]                      r_ab;
    logic signed [POSITION_BITS-1:0] r_pos;
    logic [1:0]                      n_ab;
    logic signed [POSITION_BITS-1:0] n_pos;
    logic signed [1:0]               w_dir;

    always_comb begin
        n_ab  = {i_levels[i_a_pin], i_levels[i_b_pin]};
        w_dir = mqdc_pkg::STEP_TABLE[{r_ab, n_ab}];
        n_pos = r_pos;
        // count only on arrival at the detent
        if (n_ab == mqdc_pkg::AB_DETENT) begin
            n_pos = r_pos + {{(POSITION_BITS-2){w_dir[1]}}, w_dir};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ab  <= 2'b00;
            r_pos <= '0;
        end else if (i_step) begin
            r_ab  <= n_ab;
            r_pos <= n_pos;
        end
    end

    assign o_position = r_pos;

endmodule

`default_nettype wire

>>> rtl/core/multi_quadrature_detent_counter.sv
// Eight-channel quadrature detent counter. One port sample is accepted per clock while the
// input register is empty or can move on; its result (all positions) passes through the input
// register, then the per-encoder position registers, which also serve as the result register.
// A stalled result holds the sample behind it in the input register. Depends on mqdc_pkg and mqdc_lane.
`default_nettype none

module multi_quadrature_detent_counter #(
    parameter int NUM_ENCODERS  = mqdc_pkg::NUM_ENCODERS_DEF,
    parameter int POSITION_BITS = mqdc_pkg::POSITION_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  mqdc_pkg::t_in                         i_in_data,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output mqdc_pkg::t_out                        o_out_data,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [mqdc_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire  [mqdc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    logic [mqdc_pkg::CFG_DATA_BITS-1:0] r_a_sel;
    logic [mqdc_pkg::CFG_DATA_BITS-1:0] r_b_sel;
    logic                               r_in_valid;
    mqdc_pkg::t_in                      r_in_data;
    logic                               r_out_valid;
    logic                               w_advance;
    logic                               w_step;
    logic [mqdc_pkg::PINS-1:0]          w_levels;
    logic signed [mqdc_pkg::OUT_BITS-1:0] w_pos [mqdc_pkg::LANES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_sel <= mqdc_pkg::A_PIN_SELECT_RST;
            r_b_sel <= mqdc_pkg::B_PIN_SELECT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mqdc_pkg::CFG_A_PIN_SELECT: r_a_sel <= i_cfg_data;
                mqdc_pkg::CFG_B_PIN_SELECT: r_b_sel <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // result stage is free when empty or being taken
    assign w_advance   = !r_out_valid || i_out_ready;
    assign w_step      = r_in_valid && w_advance;
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    assign w_levels = {r_in_data.port_b_bits, r_in_data.port_a_bits};

    for (genvar k = 0; k < mqdc_pkg::LANES; k++) begin : g_lane
        if (k < NUM_ENCODERS) begin : g_used
            logic signed [POSITION_BITS-1:0] w_lane_pos;

            mqdc_lane #(
                .POSITION_BITS(POSITION_BITS)
            ) u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_step    (w_step),
                .i_levels  (w_levels),
                .i_a_pin   (r_a_sel[mqdc_pkg::PIN_BITS*k +: mqdc_pkg::PIN_BITS]),
                .i_b_pin   (r_b_sel[mqdc_pkg::PIN_BITS*k +: mqdc_pkg::PIN_BITS]),
                .o_position(w_lane_pos)
            );

            // sign-extend or truncate to the output width
            assign w_pos[k] = mqdc_pkg::OUT_BITS'(w_lane_pos);
        end else begin : g_unused
            assign w_pos[k] = '0;
        end
    end

    always_comb begin
        o_out_data.enc0_position = w_pos[0];
        o_out_data.enc1_position = w_pos[1];
        o_out_data.enc2_position = w_pos[2];
        o_out_data.enc3_position = w_pos[3];
        o_out_data.enc4_position = w_pos[4];
        o_out_data.enc5_position = w_pos[5];
        o_out_data.enc6_position = w_pos[6];
        o_out_data.enc7_position = w_pos[7];
    end

endmodule

`default_nettype wire

>>> rtl/core/mqdc_checker.sv
// Port-level checks for the multi-channel quadrature detent counter, bound to the top level.
// Depends on mqdc_pkg for payload types.
`default_nettype none

module mqdc_checker (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    input  wire                                   o_in_ready,
    input  wire                                   o_out_valid,
    input  wire                                   i_out_ready,
    input  mqdc_pkg::t_out                        o_out_data,
    input  wire                                   i_cfg_valid,
    input  wire                                   o_cfg_ready
);

    // a stalled result transaction holds its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // positions move only when a new result is presented
    a_change_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(i_rst_n, 2) && !$stable(o_out_data) |-> o_out_valid)
        else $error("positions changed without a result");

    // a fresh result follows an earlier input transaction
    a_rise_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without input transaction");

    // with no result pending the input side never stalls
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result stage");

    // register writes are never held off
    a_cfg_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("register write stalled");

endmodule

bind multi_quadrature_detent_counter mqdc_checker u_mqdc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data),
    .i_cfg_valid(i_cfg_valid),
    .o_cfg_ready(o_cfg_ready)
);

`default_nettype wire

>>> verif/mqdc_checker.sv
// Port checker for the multi-channel quadrature detent counter: watches the sample, result
// and register channels, predicts every result and compares it with what the block returns.
// Depends on mqdc_pkg.
`default_nettype none

module mqdc_port_checker
    import mqdc_pkg::*;
#(
    parameter int NUM_ENCODERS  = NUM_ENCODERS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    input  wire                        i_in_ready,
    input  t_in                        i_in_data,
    input  wire                        i_out_valid,
    input  wire                        i_out_ready,
    input  t_out                       i_out_data,
    input  wire                        i_cfg_valid,
    input  wire                        i_cfg_ready,
    input  wire [CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire [CFG_DATA_BITS-1:0]    i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam int MAX_REPORTS = 10;
    localparam logic [31:0] POS_MASK =
        (POSITION_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << POSITION_BITS) - 32'd1);

    // Previous AB states that count a detent when the encoder drops into the detent
    localparam logic [1:0] AB_B_ONLY = 2'b01;
    localparam logic [1:0] AB_A_ONLY = 2'b10;

    logic [CFG_DATA_BITS-1:0] a_sel;
    logic [CFG_DATA_BITS-1:0] b_sel;
    logic [LANES-1:0]         prev_a;
    logic [LANES-1:0]         prev_b;
    logic [31:0]              enc_count [LANES];
    t_out                     expected_positions [$];
    int                       report_count;

    task automatic note_failure(input string msg);
        o_fail_count = o_fail_count + 1;
        if (report_count < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        report_count = report_count + 1;
    endtask

    // Decode one sample for every encoder and return the positions after it
    task automatic predict_positions(input t_in smp, output t_out res);
        logic [PINS-1:0]           pins;
        logic [LANES*OUT_BITS-1:0] flat;
        logic [PIN_BITS-1:0]       a_pin;
        logic [PIN_BITS-1:0]       b_pin;
        logic [1:0]                prev_ab;
        logic [1:0]                curr_ab;
        logic [31:0]               v;
        pins = {smp.port_b_bits, smp.port_a_bits};
        flat = '0;
        for (int k = 0; k < LANES; k++) begin
            if (k < NUM_ENCODERS) begin
                a_pin   = a_sel[PIN_BITS*k +: PIN_BITS];
                b_pin   = b_sel[PIN_BITS*k +: PIN_BITS];
                curr_ab = {pins[a_pin], pins[b_pin]};
                prev_ab = {prev_a[k], prev_b[k]};
                if (curr_ab == AB_DETENT) begin
                    if (prev_ab == AB_B_ONLY) begin
                        enc_count[k] = (enc_count[k] + 32'd1) & POS_MASK;
                    end else if (prev_ab == AB_A_ONLY) begin
                        enc_count[k] = (enc_count[k] - 32'd1) & POS_MASK;
                    end
                end
                prev_a[k] = curr_ab[1];
                prev_b[k] = curr_ab[0];
                v = enc_count[k] & POS_MASK;
                if (v[POSITION_BITS-1]) begin
                    v = v | ~POS_MASK;
                end
                flat[(LANES-1-k)*OUT_BITS +: OUT_BITS] = v[OUT_BITS-1:0];
            end
        end
        res = t_out'(flat);
    endtask

    always @(posedge i_clk) begin
        t_out                      want;
        t_out                      pred;
        logic [LANES*OUT_BITS-1:0] want_flat;
        logic [LANES*OUT_BITS-1:0] got_flat;
        logic [OUT_BITS-1:0]       e;
        logic [OUT_BITS-1:0]       g;
        if (!i_rst_n) begin
            a_sel        = A_PIN_SELECT_RST;
            b_sel        = B_PIN_SELECT_RST;
            prev_a       = '0;
            prev_b       = '0;
            o_fail_count = 0;
            report_count = 0;
            for (int k = 0; k < LANES; k++) begin
                enc_count[k] = '0;
            end
            expected_positions.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_positions.size() == 0) begin
                    note_failure($sformatf("result %h with no sample pending", i_out_data));
                end else begin
                    want      = expected_positions.pop_front();
                    want_flat = want;
                    got_flat  = i_out_data;
                    for (int k = 0; k < LANES; k++) begin
                        e = want_flat[(LANES-1-k)*OUT_BITS +: OUT_BITS];
                        g = got_flat[(LANES-1-k)*OUT_BITS +: OUT_BITS];
                        if (g !== e) begin
                            note_failure($sformatf("enc%0d_position expected %0d, got %0d",
                                                   k, $signed(e), $signed(g)));
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_positions(i_in_data, pred);
                expected_positions.push_back(pred);
            end
            // Apply writes after the sample of the same edge
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_A_PIN_SELECT: a_sel = i_cfg_data;
                    CFG_B_PIN_SELECT: b_sel = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = expected_positions.size();
    end

endmodule

`default_nettype wire

>>> verif/multi_quadrature_detent_counter_tb.sv
// Testbench top for the multi-channel quadrature detent counter: drives port samples and
// register writes with random idling, and gives the verdict from the checker's failure count.
// Depends on mqdc_pkg, mqdc_port_checker and the block itself.
`default_nettype none

module multi_quadrature_detent_counter_tb;
    import mqdc_pkg::*;

    localparam int  DRAIN_CYCLES  = 6;
    localparam int  CYCLE_LIMIT   = 600000;
    localparam int  RAND_PHASES   = 6;
    localparam int  PHASE_ITEMS   = 150;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_FIRST =
        CFG_INDEX_BITS'(CFG_B_PIN_SELECT + 1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_LAST  = '1;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    t_in                       in_data;
    logic                      out_valid;
    logic                      out_ready;
    t_out                      out_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int                        fail_count;
    int                        pending;
    int                        cycle_count = 0;
    bit                        no_idle;

    // Pin maps currently in the block, used only to shape the stimulus
    logic [CFG_DATA_BITS-1:0]  a_map;
    logic [CFG_DATA_BITS-1:0]  b_map;
    int                        enc_phase [LANES];

    multi_quadrature_detent_counter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    mqdc_port_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before taking each transaction
    initial begin : result_sink
        int stall;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic send_sample(input logic [PORT_BITS-1:0] pa, input logic [PORT_BITS-1:0] pb);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in'({pa, pb});
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    // Hold off samples until every result is back and the pipeline is empty
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_A_PIN_SELECT) a_map = data;
        if (idx == CFG_B_PIN_SELECT) b_map = data;
    endtask

    function automatic logic [1:0] gray_code(input int p);
        case (p & 3)
            0:       return AB_DETENT;
            1:       return 2'b01;
            2:       return 2'b11;
            default: return 2'b10;
        endcase
    endfunction

    // Advance each encoder along its quadrature sequence, with an occasional skipped state
    task automatic walk_sample();
        logic [PINS-1:0] pins;
        logic [1:0]      ab;
        int              r;
        pins = PINS'($urandom);
        for (int k = 0; k < LANES; k++) begin
            r = $urandom_range(0, 15);
            if (r < 6) enc_phase[k] = (enc_phase[k] + 1) & 3;
            else if (r < 12) enc_phase[k] = (enc_phase[k] + 3) & 3;
            else if (r == 15) enc_phase[k] = (enc_phase[k] + 2) & 3;
            ab = gray_code(enc_phase[k]);
            pins[a_map[PIN_BITS*k +: PIN_BITS]] = ab[1];
            pins[b_map[PIN_BITS*k +: PIN_BITS]] = ab[0];
        end
        send_sample(pins[PORT_BITS-1:0], pins[PINS-1:PORT_BITS]);
    endtask

    // Either a shuffle of all sixteen pins or two fully random words
    task automatic random_pin_maps(output logic [CFG_DATA_BITS-1:0] a_word,
                                   output logic [CFG_DATA_BITS-1:0] b_word);
        int perm [PINS];
        int j;
        int t;
        if ($urandom_range(0, 2) == 0) begin
            a_word = $urandom;
            b_word = $urandom;
        end else begin
            for (int i = 0; i < PINS; i++) perm[i] = i;
            for (int i = PINS - 1; i > 0; i--) begin
                j       = $urandom_range(0, i);
                t       = perm[i];
                perm[i] = perm[j];
                perm[j] = t;
            end
            for (int k = 0; k < LANES; k++) begin
                a_word[PIN_BITS*k +: PIN_BITS] = perm[k][PIN_BITS-1:0];
                b_word[PIN_BITS*k +: PIN_BITS] = perm[k+LANES][PIN_BITS-1:0];
            end
        end
    endtask

    initial begin : stimulus
        logic [CFG_DATA_BITS-1:0] a_word;
        logic [CFG_DATA_BITS-1:0] b_word;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        no_idle     = 1'b0;
        a_map       = A_PIN_SELECT_RST;
        b_map       = B_PIN_SELECT_RST;
        for (int k = 0; k < LANES; k++) enc_phase[k] = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset pin maps: port extremes and opposite half patterns into the detent
        send_sample(8'h00, 8'h00);
        send_sample(8'hFF, 8'hFF);
        send_sample(8'h00, 8'h00);
        send_sample(8'h55, 8'h55);
        send_sample(8'h00, 8'h00);
        send_sample(8'hAA, 8'hAA);
        send_sample(8'h00, 8'h00);
        send_sample(8'h55, 8'hAA);
        repeat (4) walk_sample();

        // Writes beyond the last register must leave the maps alone
        write_reg(CFG_UNUSED_FIRST, $urandom);
        write_reg(CFG_UNUSED_LAST, $urandom);
        send_sample(8'hAA, 8'h55);
        send_sample(8'h00, 8'h00);
        send_sample(8'hFF, 8'h00);

        // Same pin for A and B on every encoder
        write_reg(CFG_A_PIN_SELECT, '0);
        write_reg(CFG_B_PIN_SELECT, '0);
        send_sample(8'h01, 8'h00);
        send_sample(8'h00, 8'h00);
        send_sample(8'h01, 8'h00);
        send_sample(8'h00, 8'h00);

        // A on the top pin, B on the bottom pin, then swapped
        write_reg(CFG_A_PIN_SELECT, '1);
        send_sample(8'h00, 8'h80);
        send_sample(8'h00, 8'h00);
        send_sample(8'h01, 8'h00);
        send_sample(8'h00, 8'h00);
        write_reg(CFG_A_PIN_SELECT, '0);
        write_reg(CFG_B_PIN_SELECT, '1);
        send_sample(8'h00, 8'h80);
        send_sample(8'h00, 8'h00);

        write_reg(CFG_A_PIN_SELECT, A_PIN_SELECT_RST);
        write_reg(CFG_B_PIN_SELECT, B_PIN_SELECT_RST);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph > 0) begin
                random_pin_maps(a_word, b_word);
                write_reg(CFG_A_PIN_SELECT, a_word);
                write_reg(CFG_B_PIN_SELECT, b_word);
                if ($urandom_range(0, 2) == 0) begin
                    write_reg(CFG_INDEX_BITS'($urandom_range(CFG_UNUSED_FIRST,
                                                             CFG_UNUSED_LAST)), $urandom);
                end
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
                if (i == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 0) drain_results();
                if ($urandom_range(0, 4) == 0) begin
                    send_sample(PORT_BITS'($urandom), PORT_BITS'($urandom));
                end else begin
                    walk_sample();
                end
            end
            no_idle = 1'b0;
        end

        drain_results();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
